/* hw/rtl/multichannel_moving_average_macros.svh */
// ----------------------------------------------------------------------------
// Multichannel moving average - assertion macros
// Clocked implication checks shared by the block's assertion section.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define MMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mma_pkg.sv */
// ----------------------------------------------------------------------------
// Multichannel moving average - package
// Field widths, stream packing and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int MV_W      = 12;
    localparam int SEEN_W    = 32;
    localparam int PROD_W    = SAMPLE_W + MV_W;
    localparam int STEP_W    = $clog2(SAMPLE_W);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [MV_W-1:0] FULL_SCALE_MV = MV_W'(3300);

    typedef struct packed {
        logic busy;
        logic done;
    } mma_div_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/mma_divider.sv */
// ----------------------------------------------------------------------------
// Multichannel moving average - iterative divider
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_divider
    import mma_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int DIV_W = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [SUM_W-1:0]    dividend,
    input  wire logic [DIV_W-1:0]    divisor,
    output logic      [SAMPLE_W-1:0] quotient,
    output mma_div_stat_t            stat
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [DIV_W-1:0]    dvs_reg;

    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                ge;
    logic [DIV_W-1:0]    rem_next;

    assign trial    = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(SAMPLE_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SAMPLE_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_W'(dividend >> SAMPLE_W);
            quo_reg <= dividend[SAMPLE_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SAMPLE_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/multichannel_moving_average.sv */
// ----------------------------------------------------------------------------
// Multichannel moving average - top level
// Per-channel ring of the last WINDOW samples with running sum; reports the
// mean, the mean in millivolts, the full flag and the channel sample count.
// ----------------------------------------------------------------------------
// Order: an accepted transaction passes ring read, the 16-step shared divider,
//   multiply and scale states to m_tvalid; only then is a new one taken.
// Out-of-range channels are accepted and dropped without leaving idle.
// Reset: aresetn clears sums, positions, full flags and counters at once;
//   ring entries are not cleared and are always written before being used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int CHANNELS = 6,
    parameter int WINDOW   = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] channel, [18:3] sample, [23:19] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] channel_out, [18:3] average, [30:19] voltage_mv,
    // [31] win_full, [63:32] samples_seen
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [CHAN_W-1:0]   in_channel;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_ch_ok;
    logic [CH_IDX_W-1:0] in_idx;
    logic                accept;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;

    logic [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic [SAMPLE_W-1:0] ring_rd_reg;

    logic [SUM_W-1:0]    sum_reg  [CHANNELS];
    logic [POS_W-1:0]    pos_reg  [CHANNELS];
    logic                full_reg [CHANNELS];
    logic [SEEN_W-1:0]   seen_reg [CHANNELS];

    logic [CH_IDX_W-1:0] ch_reg;
    logic [CHAN_W-1:0]   chan_out_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic                cur_full;
    logic [POS_W-1:0]    cur_pos;
    logic                wrap;
    logic [POS_W-1:0]    new_pos;
    logic                new_full;
    logic [SUM_W-1:0]    new_sum;
    logic [SEEN_W-1:0]   new_seen;
    logic [CNT_W-1:0]    divisor;
    logic                div_start;
    logic [SAMPLE_W-1:0] div_quotient;
    mma_div_stat_t       div_stat;

    logic                full_res_reg;
    logic [SEEN_W-1:0]   seen_res_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W:0]     scale_sum;
    logic [MV_W-1:0]     mv;
    logic                out_load;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign in_channel = s_tdata[CHAN_W-1:0];
    assign in_sample  = s_tdata[CHAN_W +: SAMPLE_W];
    assign in_ch_ok   = (int'(in_channel) < CHANNELS);
    assign in_idx     = in_ch_ok ? CH_IDX_W'(in_channel) : '0;
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign wr_en      = accept && in_ch_ok;
    assign wr_addr    = ADDR_W'(in_idx) * ADDR_W'(WINDOW) + ADDR_W'(pos_reg[in_idx]);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_rd_reg       <= ring_mem[wr_addr];
            ring_mem[wr_addr] <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ch_reg       <= in_idx;
            chan_out_reg <= in_channel;
            sample_reg   <= in_sample;
        end
    end

    assign cur_full = full_reg[ch_reg];
    assign cur_pos  = pos_reg[ch_reg];
    assign wrap     = (cur_pos == POS_W'(WINDOW - 1));
    assign new_pos  = wrap ? '0 : cur_pos + 1'b1;
    assign new_full = cur_full | wrap;
    assign new_sum  = sum_reg[ch_reg]
                    - (cur_full ? SUM_W'(ring_rd_reg) : '0)
                    + SUM_W'(sample_reg);
    assign new_seen = seen_reg[ch_reg] + 1'b1;
    assign divisor  = new_full ? CNT_W'(WINDOW) : CNT_W'(new_pos);
    assign div_start = (state_reg == ST_READ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]  <= '0;
                pos_reg[i]  <= '0;
                full_reg[i] <= 1'b0;
                seen_reg[i] <= '0;
            end
        end else if (state_reg == ST_READ) begin
            sum_reg[ch_reg]  <= new_sum;
            pos_reg[ch_reg]  <= new_pos;
            full_reg[ch_reg] <= new_full;
            seen_reg[ch_reg] <= new_seen;
        end
    end

    mma_divider #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign scale_sum = {1'b0, prod_reg} + (PROD_W + 1)'(prod_reg >> SAMPLE_W) + 1'b1;
    assign mv        = scale_sum[SAMPLE_W +: MV_W];
    assign out_load  = (state_reg == ST_SCALE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            full_res_reg <= new_full;
            seen_res_reg <= new_seen;
        end
        if (state_reg == ST_DIV && div_stat.done) begin
            avg_reg <= div_quotient;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(FULL_SCALE_MV);
        end
        if (out_load) begin
            m_tdata_reg <= {seen_res_reg, full_res_reg, mv, avg_reg, chan_out_reg};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (wr_en) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MMA_ASSERT_NEXT(a_drop_bad_channel, aclk, aresetn,
        accept && !in_ch_ok, s_tready, "out-of-range channel not dropped")
    `MMA_ASSERT_NEXT(a_good_channel_reads, aclk, aresetn,
        wr_en, state_reg == ST_READ, "accepted sample did not start ring read")
    `MMA_ASSERT_SAME(a_div_busy_while_waiting, aclk, aresetn,
        state_reg == ST_DIV && !div_stat.done, div_stat.busy,
        "divider idle while sequencer waits")
    `MMA_ASSERT_SAME(a_result_from_scale, aclk, aresetn,
        $rose(m_tvalid), $past(state_reg) == ST_SCALE, "result raised outside scale step")

endmodule

`default_nettype wire

/* verif/tb_multichannel_moving_average.sv */
// ----------------------------------------------------------------------------
// Multichannel moving average - testbench
// Drives channel/sample transactions into the filter and predicts the average,
// millivolt value, full flag and sample count of every in-range channel from
// a behavioral copy of the per-channel rings. Each output transaction is
// compared field by field with the oldest prediction. Directed extremes come
// first, then random traffic under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_multichannel_moving_average;
    import mma_pkg::*;

    localparam int          CHANNELS      = 6;
    localparam int          WINDOW        = 10;
    localparam int unsigned CODE_MAX      = 65535;
    localparam int unsigned MV_SCALE      = 3300;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          PHASE_ITEMS   = 600;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel_out;
        logic [SAMPLE_W-1:0] average;
        logic [MV_W-1:0]     voltage_mv;
        logic                win_full;
        logic [SEEN_W-1:0]   samples_seen;
    } channel_average_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] channel, [18:3] sample, [23:19] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [2:0] channel_out, [18:3] average, [30:19] voltage_mv,
    // [31] win_full, [63:32] samples_seen
    logic [M_TDATA_W-1:0] m_tdata;

    logic [SAMPLE_W-1:0] ring_entry [CHANNELS][WINDOW];
    logic [31:0]         ring_sum   [CHANNELS] = '{default: '0};
    int unsigned         next_slot  [CHANNELS] = '{default: 0};
    logic                ring_full  [CHANNELS] = '{default: 1'b0};
    logic [SEEN_W-1:0]   seen_count [CHANNELS] = '{default: '0};

    channel_average_t pending_averages [$];
    channel_average_t expected_average;
    channel_average_t observed_average;
    int unsigned      mismatch_count = 0;
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_idle_pct  = 0;

    multichannel_moving_average #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic channel_average_t next_channel_average(
        input logic [CHAN_W-1:0]   ch,
        input logic [SAMPLE_W-1:0] smp
    );
        channel_average_t res;
        int unsigned      pos;
        int unsigned      fill;
        logic [31:0]      mean;
        pos = next_slot[ch];
        if (ring_full[ch]) begin
            ring_sum[ch] -= ring_entry[ch][pos];
        end
        ring_entry[ch][pos] = smp;
        ring_sum[ch] += smp;
        pos = (pos + 1) % WINDOW;
        next_slot[ch] = pos;
        if (pos == 0) begin
            ring_full[ch] = 1'b1;
        end
        fill = ring_full[ch] ? WINDOW : pos;
        mean = ring_sum[ch] / fill;
        seen_count[ch] += 1'b1;
        res.channel_out  = ch;
        res.average      = mean[SAMPLE_W-1:0];
        res.voltage_mv   = MV_W'((32'(mean[SAMPLE_W-1:0]) * MV_SCALE) / CODE_MAX);
        res.win_full     = ring_full[ch];
        res.samples_seen = seen_count[ch];
        return res;
    endfunction

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, smp, ch};
        do @(posedge aclk); while (!s_tready);
        if (ch < CHANNELS) begin
            pending_averages.push_back(next_channel_average(ch, smp));
        end
    endtask

    // hold off the sender until every pending average has been returned
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed;
        send_sample(3'd7, 16'hFFFF);
        send_sample(3'd6, 16'h0000);
        repeat (WINDOW + 1) send_sample(3'd0, 16'hFFFF);
        send_sample(3'd5, 16'h0000);
        send_sample(3'd1, 16'h5555);
        send_sample(3'd1, 16'hAAAA);
        send_sample(3'd2, 16'h8000);
        send_sample(3'd3, 16'h0001);
        send_sample(3'd4, 16'h7FFE);
        wait_for_results;
    endtask

    task automatic test_random_phase(
        input int unsigned sender_pct,
        input int unsigned receiver_pct,
        input int          item_count
    );
        int                  accepted;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] smp;
        accepted      = 0;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        while (accepted < item_count) begin
            if ($urandom_range(9) == 0) begin
                ch = CHAN_W'($urandom_range(7, CHANNELS));
            end else begin
                ch = CHAN_W'($urandom_range(CHANNELS - 1));
            end
            case ($urandom_range(3))
                0:       smp = SAMPLE_W'($urandom);
                1:       smp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                2:       smp = 16'h8000 + SAMPLE_W'($urandom_range(255)) - 16'd128;
                default: smp = SAMPLE_W'($urandom_range(65535));
            endcase
            send_sample(ch, smp);
            if (ch < CHANNELS) begin
                accepted++;
            end
        end
        wait_for_results;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed_average.channel_out  = m_tdata[2:0];
            observed_average.average      = m_tdata[18:3];
            observed_average.voltage_mv   = m_tdata[30:19];
            observed_average.win_full     = m_tdata[31];
            observed_average.samples_seen = m_tdata[63:32];
            if (pending_averages.size() == 0) begin
                $error("unexpected output transaction m_tdata=%h", m_tdata);
                mismatch_count++;
            end else begin
                expected_average = pending_averages.pop_front();
                if (observed_average.channel_out != expected_average.channel_out) begin
                    $error("channel_out: expected %0d, actual %0d",
                           expected_average.channel_out, observed_average.channel_out);
                    mismatch_count++;
                end
                if (observed_average.average != expected_average.average) begin
                    $error("average: expected %0d, actual %0d",
                           expected_average.average, observed_average.average);
                    mismatch_count++;
                end
                if (observed_average.voltage_mv != expected_average.voltage_mv) begin
                    $error("voltage_mv: expected %0d, actual %0d",
                           expected_average.voltage_mv, observed_average.voltage_mv);
                    mismatch_count++;
                end
                if (observed_average.win_full != expected_average.win_full) begin
                    $error("win_full: expected %0d, actual %0d",
                           expected_average.win_full, observed_average.win_full);
                    mismatch_count++;
                end
                if (observed_average.samples_seen != expected_average.samples_seen) begin
                    $error("samples_seen: expected %0d, actual %0d",
                           expected_average.samples_seen, observed_average.samples_seen);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 29;
        recv_idle_pct = 70;
        test_directed;
        test_random_phase(29, 70, PHASE_ITEMS);
        test_random_phase(70, 29, PHASE_ITEMS);
        test_random_phase(0, 0, PHASE_ITEMS);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
